// File: src/assert_macros.svh
// assertion macros shared by the route table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds on every clock edge out of reset
`define LPMR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lpmr assertion failed");

// consequent holds in the same cycle as the antecedent
`define LPMR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpmr assertion failed");

// consequent holds in the cycle after the antecedent
`define LPMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpmr assertion failed");

`else

`define LPMR_ASSERT(label, clk, rst_n, prop)
`define LPMR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LPMR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: src/lpmr_pkg.sv
// types and constants for the longest prefix match route table
package lpmr_pkg;

    localparam int ADDR_BITS       = 32;
    localparam int LEN_BITS        = 6;
    localparam int TTL_BITS        = 8;
    localparam int DEF_ROUTE_SLOTS = 32;
    localparam int DEF_IFACE_BITS  = 4;

    localparam logic [LEN_BITS-1:0] MAX_LEN = 6'd32;
    localparam logic [TTL_BITS-1:0] TTL_MIN = 8'd1;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_ROUTE = 1'b1;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_REPLACED  = 3'd1,
        ST_FULL      = 3'd2,
        ST_FORWARDED = 3'd3,
        ST_TTL       = 3'd4,
        ST_NOROUTE   = 3'd5
    } status_t;

    // request travelling down the chain with the search results so far
    typedef struct packed {
        logic                 valid;
        logic                 kind;
        logic [ADDR_BITS-1:0] addr;
        logic [LEN_BITS-1:0]  len;
        logic                 hit_found;
        logic                 free_found;
        logic                 best_found;
        logic [LEN_BITS-1:0]  best_len;
        logic                 best_has_hop;
        logic [ADDR_BITS-1:0] best_hop;
    } token_t;

    // slot update broadcast to every cell
    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] prefix;
        logic [LEN_BITS-1:0]  len;
        logic                 has_hop;
        logic [ADDR_BITS-1:0] hop;
    } write_t;

endpackage

// File: src/lpmr_cell.sv
// one route slot with its compare logic and a token stage of the chain
`include "assert_macros.svh"

module lpmr_cell #(
    parameter int SLOT_BITS  = 5,
    parameter int IFACE_BITS = lpmr_pkg::DEF_IFACE_BITS,
    parameter logic [SLOT_BITS-1:0] SLOT_INDEX = '0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lpmr_pkg::token_t       tok_in,
    input  logic [SLOT_BITS-1:0]   hit_idx_in,
    input  logic [SLOT_BITS-1:0]   free_idx_in,
    input  logic [IFACE_BITS-1:0]  best_iface_in,
    output lpmr_pkg::token_t       tok_out,
    output logic [SLOT_BITS-1:0]   hit_idx_out,
    output logic [SLOT_BITS-1:0]   free_idx_out,
    output logic [IFACE_BITS-1:0]  best_iface_out,
    input  lpmr_pkg::write_t       wr,
    input  logic [SLOT_BITS-1:0]   wr_idx,
    input  logic [IFACE_BITS-1:0]  wr_iface
);
    import lpmr_pkg::*;

    logic                  used_reg;
    logic [ADDR_BITS-1:0]  prefix_reg;
    logic [LEN_BITS-1:0]   length_reg;
    logic                  has_hop_reg;
    logic [ADDR_BITS-1:0]  hop_reg;
    logic [IFACE_BITS-1:0] iface_reg;

    token_t                tok_reg;
    token_t                tok_next;
    logic [SLOT_BITS-1:0]  hit_idx_reg;
    logic [SLOT_BITS-1:0]  hit_idx_next;
    logic [SLOT_BITS-1:0]  free_idx_reg;
    logic [SLOT_BITS-1:0]  free_idx_next;
    logic [IFACE_BITS-1:0] best_iface_reg;
    logic [IFACE_BITS-1:0] best_iface_next;

    logic                  wr_here;
    logic [ADDR_BITS-1:0]  mask;

    assign wr_here = wr.en && (wr_idx == SLOT_INDEX);
    assign mask    = ~({ADDR_BITS{1'b1}} >> length_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (wr_here)
        begin
            used_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            prefix_reg  <= wr.prefix;
            length_reg  <= wr.len;
            has_hop_reg <= wr.has_hop;
            hop_reg     <= wr.hop;
            iface_reg   <= wr_iface;
        end
    end

    always_comb
    begin
        tok_next        = tok_in;
        hit_idx_next    = hit_idx_in;
        free_idx_next   = free_idx_in;
        best_iface_next = best_iface_in;
        if (used_reg)
        begin
            // exact entry for replacement
            if (!tok_in.hit_found && prefix_reg == tok_in.addr && length_reg == tok_in.len)
            begin
                tok_next.hit_found = 1'b1;
                hit_idx_next       = SLOT_INDEX;
            end
            // strictly longer match wins, so the lowest slot keeps a tie
            if ((tok_in.addr & mask) == prefix_reg
                && (!tok_in.best_found || length_reg > tok_in.best_len))
            begin
                tok_next.best_found   = 1'b1;
                tok_next.best_len     = length_reg;
                tok_next.best_has_hop = has_hop_reg;
                tok_next.best_hop     = hop_reg;
                best_iface_next       = iface_reg;
            end
        end
        else if (!tok_in.free_found)
        begin
            tok_next.free_found = 1'b1;
            free_idx_next       = SLOT_INDEX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg    <= hit_idx_next;
        free_idx_reg   <= free_idx_next;
        best_iface_reg <= best_iface_next;
    end

    assign tok_out        = tok_reg;
    assign hit_idx_out    = hit_idx_reg;
    assign free_idx_out   = free_idx_reg;
    assign best_iface_out = best_iface_reg;

    `LPMR_ASSERT_NEXT(a_cell_claims_slot, clk, rst_n, wr_here, used_reg)
    `LPMR_ASSERT_IMPL(a_cell_best_len, clk, rst_n, tok_reg.best_found, tok_reg.best_len <= MAX_LEN)
    `LPMR_ASSERT_NEXT(a_cell_token_moves, clk, rst_n, tok_in.valid, tok_reg.valid)

endmodule

// File: src/longest_prefix_match_router.sv
// ipv4 longest prefix match route table built as a chain of slot cells
//
//   channel  handshake             payload
//   in       in_valid / in_stall   kind address prefix_len hop_given hop_address iface_in ttl_in
//   out      out_valid / out_stall status out_iface out_hop out_ttl
//
// a beat walks the chain one cell per cycle, through the token register of every
// slot cell, then waits in the result holding register
// in_stall stays high from the accepted beat until its result moves into the
// output register, so a new beat is taken only once the last one has left
// route updates land in the slot cells as the beat leaves the chain
// reset clears every slot valid bit; a stalled output holds back the next beat
`include "assert_macros.svh"

module longest_prefix_match_router #(
    parameter int ROUTE_SLOTS = lpmr_pkg::DEF_ROUTE_SLOTS,
    parameter int IFACE_BITS  = lpmr_pkg::DEF_IFACE_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   kind,
    input  logic [31:0]            address,
    input  logic [5:0]             prefix_len,
    input  logic                   hop_given,
    input  logic [31:0]            hop_address,
    input  logic [IFACE_BITS-1:0]  iface_in,
    input  logic [7:0]             ttl_in,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             status,
    output logic [IFACE_BITS-1:0]  out_iface,
    output logic [31:0]            out_hop,
    output logic [7:0]             out_ttl
);
    import lpmr_pkg::*;

    localparam int SLOT_BITS = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;

    token_t                tok        [0:ROUTE_SLOTS];
    logic [SLOT_BITS-1:0]  hit_idx    [0:ROUTE_SLOTS];
    logic [SLOT_BITS-1:0]  free_idx   [0:ROUTE_SLOTS];
    logic [IFACE_BITS-1:0] best_iface [0:ROUTE_SLOTS];
    logic [ROUTE_SLOTS-1:0] tok_busy;

    token_t                head_tok;
    token_t                last;
    write_t                wr;
    logic [SLOT_BITS-1:0]  wr_idx;

    logic                  accept;
    logic                  exit_beat;
    logic                  move;

    logic                  busy_reg;
    logic                  busy_next;
    logic                  pend_reg;
    logic                  pend_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    logic                  req_hop_given_reg;
    logic [ADDR_BITS-1:0]  req_hop_reg;
    logic [IFACE_BITS-1:0] req_iface_reg;

    status_t               res_status;
    logic [IFACE_BITS-1:0] res_iface;
    logic [ADDR_BITS-1:0]  res_hop;
    logic [TTL_BITS-1:0]   res_ttl;
    logic [TTL_BITS-1:0]   ttl_reg;

    status_t               pend_status_reg;
    logic [IFACE_BITS-1:0] pend_iface_reg;
    logic [ADDR_BITS-1:0]  pend_hop_reg;
    logic [TTL_BITS-1:0]   pend_ttl_reg;

    status_t               out_status_reg;
    logic [IFACE_BITS-1:0] out_iface_reg;
    logic [ADDR_BITS-1:0]  out_hop_reg;
    logic [TTL_BITS-1:0]   out_ttl_reg;

    assign accept    = in_valid && !busy_reg;
    assign in_stall  = busy_reg;
    assign last      = tok[ROUTE_SLOTS];
    assign exit_beat = last.valid;
    assign move      = pend_reg && (!out_valid_reg || !out_stall);

    // chain head
    always_comb
    begin
        head_tok       = '0;
        head_tok.valid = accept;
        head_tok.kind  = kind;
        head_tok.addr  = address;
        head_tok.len   = (prefix_len > MAX_LEN) ? MAX_LEN : prefix_len;
    end

    assign tok[0]        = head_tok;
    assign hit_idx[0]    = '0;
    assign free_idx[0]   = '0;
    assign best_iface[0] = '0;

    genvar i;
    generate
        for (i = 0; i < ROUTE_SLOTS; i++)
        begin : g_cell
            lpmr_cell #(
                .SLOT_BITS  (SLOT_BITS),
                .IFACE_BITS (IFACE_BITS),
                .SLOT_INDEX (SLOT_BITS'(i))
            ) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .tok_in         (tok[i]),
                .hit_idx_in     (hit_idx[i]),
                .free_idx_in    (free_idx[i]),
                .best_iface_in  (best_iface[i]),
                .tok_out        (tok[i+1]),
                .hit_idx_out    (hit_idx[i+1]),
                .free_idx_out   (free_idx[i+1]),
                .best_iface_out (best_iface[i+1]),
                .wr             (wr),
                .wr_idx         (wr_idx),
                .wr_iface       (req_iface_reg)
            );
            assign tok_busy[i] = tok[i+1].valid;
        end
    endgenerate

    // request fields only needed when the beat leaves the chain
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_hop_given_reg <= hop_given;
            req_hop_reg       <= hop_address;
            req_iface_reg     <= iface_in;
            ttl_reg           <= ttl_in;
        end
    end

    // slot update and result as the beat leaves the chain
    always_comb
    begin
        wr         = '0;
        wr_idx     = last.hit_found ? hit_idx[ROUTE_SLOTS] : free_idx[ROUTE_SLOTS];
        wr.prefix  = last.addr;
        wr.len     = last.len;
        wr.has_hop = req_hop_given_reg;
        wr.hop     = req_hop_reg;
        res_iface  = '0;
        res_hop    = '0;
        res_ttl    = '0;
        if (last.kind == KIND_ADD)
        begin
            wr.en = exit_beat && (last.hit_found || last.free_found);
            if (last.hit_found)
            begin
                res_status = ST_REPLACED;
            end
            else if (last.free_found)
            begin
                res_status = ST_ADDED;
            end
            else
            begin
                res_status = ST_FULL;
            end
        end
        else if (ttl_reg <= TTL_MIN)
        begin
            res_status = ST_TTL;
        end
        else if (last.best_found)
        begin
            res_status = ST_FORWARDED;
            res_iface  = best_iface[ROUTE_SLOTS];
            res_hop    = last.best_has_hop ? last.best_hop : last.addr;
            res_ttl    = ttl_reg - TTL_MIN;
        end
        else
        begin
            res_status = ST_NOROUTE;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (move)
        begin
            busy_next = 1'b0;
        end
        pend_next      = exit_beat ? 1'b1 : (pend_reg && !move);
        out_valid_next = move ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exit_beat)
        begin
            pend_status_reg <= res_status;
            pend_iface_reg  <= res_iface;
            pend_hop_reg    <= res_hop;
            pend_ttl_reg    <= res_ttl;
        end
        if (move)
        begin
            out_status_reg <= pend_status_reg;
            out_iface_reg  <= pend_iface_reg;
            out_hop_reg    <= pend_hop_reg;
            out_ttl_reg    <= pend_ttl_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign out_iface = out_iface_reg;
    assign out_hop   = out_hop_reg;
    assign out_ttl   = out_ttl_reg;

    `LPMR_ASSERT(a_one_beat_in_chain, clk, rst_n, $onehot0(tok_busy))
    `LPMR_ASSERT_IMPL(a_accept_when_empty, clk, rst_n, accept, !pend_reg && tok_busy == '0)
    `LPMR_ASSERT_NEXT(a_exit_fills_pend, clk, rst_n, exit_beat, pend_reg)
    `LPMR_ASSERT_IMPL(a_fwd_ttl_nonzero, clk, rst_n, out_valid_reg && out_status_reg == ST_FORWARDED, out_ttl_reg != '0)

endmodule
